>>> hdl/morse_symbol_led_keyer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Morse keyer
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MORSE_SYMBOL_LED_KEYER_TOP_ASSERT_SVH
`define MORSE_SYMBOL_LED_KEYER_TOP_ASSERT_SVH

// Same-cycle implication.
`define MSLK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSLK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mslk_pkg.sv
// ---------------------------------------------------------------------------
// mslk_pkg
// Types and constants shared by the Morse keyer modules.
// ---------------------------------------------------------------------------
package mslk_pkg;

  // Item modes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Symbol codes
  localparam logic [7:0] SYM_DOT        = 8'h2E;  // '.'
  localparam logic [7:0] SYM_DASH       = 8'h2D;  // '-'
  localparam logic [7:0] SYM_LETTER_GAP = 8'h2C;  // ','
  localparam logic [7:0] SYM_WORD_GAP   = 8'h20;  // ' '
  localparam logic [7:0] SYM_RESTART    = 8'h2F;  // '/'

  // Units per symbol
  localparam logic [2:0] LEN_DOT        = 3'd1;
  localparam logic [2:0] LEN_DASH       = 3'd3;
  localparam logic [2:0] LEN_LETTER_GAP = 3'd2;
  localparam logic [2:0] LEN_WORD_GAP   = 3'd6;

  // Register reset values
  localparam logic [15:0] PERIOD_RESET = 16'd1800;
  localparam logic [7:0]  BLANK_RESET  = 8'd5;

  // Register index codes (paddr[2])
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_BLANK  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] write_address;
    logic [7:0] write_char;
  } in_word_t;

  typedef struct packed {
    logic light_on;
    logic message_changed;
  } out_word_t;

  // Keyer counters and light level
  typedef struct packed {
    logic [2:0]  unit_cnt;
    logic [15:0] period_cnt;
    logic [7:0]  blank_cnt;
    logic        light;
  } cnt_t;

endpackage

>>> hdl/mslk_step.sv
// ---------------------------------------------------------------------------
// mslk_step
// Next-state logic of one tick: period event, blanking, symbol decode.
// ---------------------------------------------------------------------------
module mslk_step #(
  parameter int MESSAGE_DEPTH = 256
) (
  input  logic [$clog2(MESSAGE_DEPTH)-1:0] pos,
  input  mslk_pkg::cnt_t                   cnt,
  input  logic [15:0]                      period_ticks,
  input  logic [7:0]                       blank_ticks,
  input  logic [7:0]                       sym,
  input  logic [7:0]                       zero_sym,
  output logic [$clog2(MESSAGE_DEPTH)-1:0] pos_nxt,
  output mslk_pkg::cnt_t                   cnt_nxt,
  output logic                             changed
);
  import mslk_pkg::*;

  localparam int POS_W = $clog2(MESSAGE_DEPTH);

  logic [POS_W-1:0] p;
  logic [POS_W-1:0] p_inc;
  logic [7:0]       s;
  logic [2:0]       len;
  logic [2:0]       u_inc;
  cnt_t             c;

  always_comb begin
    changed = (cnt.period_cnt == period_ticks);
    c = cnt;
    p = pos;
    s = sym;
    len = LEN_DOT;
    if (changed) begin
      c.period_cnt = '0;
      c.unit_cnt   = '0;
      c.blank_cnt  = blank_ticks;
      p            = '0;
    end
    if (c.blank_cnt != 8'd0) begin
      c.light     = 1'b0;
      c.blank_cnt = c.blank_cnt - 8'd1;
    end else begin
      c.period_cnt = c.period_cnt + 16'd1;
      // restart in the same tick
      if (s == SYM_RESTART) begin
        p = '0;
        s = zero_sym;
      end
    end
    p_inc = (p == POS_W'(MESSAGE_DEPTH - 1)) ? '0 : p + 1'b1;
    u_inc = c.unit_cnt + 3'd1;
    if (cnt.blank_cnt == 8'd0 || changed) begin
      if (c.blank_cnt == 8'd0 && !(changed && blank_ticks != 8'd0)) begin
        if (s == SYM_DOT || s == SYM_DASH) begin
          len = (s == SYM_DOT) ? LEN_DOT : LEN_DASH;
          if (c.unit_cnt != len) begin
            c.light    = 1'b1;
            c.unit_cnt = u_inc;
          end else begin
            c.light    = 1'b0;
            c.unit_cnt = '0;
            p          = p_inc;
          end
        end else if (s == SYM_LETTER_GAP || s == SYM_WORD_GAP) begin
          len = (s == SYM_LETTER_GAP) ? LEN_LETTER_GAP : LEN_WORD_GAP;
          c.light = 1'b0;
          if (u_inc == len) begin
            c.unit_cnt = '0;
            p          = p_inc;
          end else begin
            c.unit_cnt = u_inc;
          end
        end else begin
          p = '0;
        end
      end
    end
    pos_nxt = p;
    cnt_nxt = c;
  end

endmodule

>>> hdl/morse_symbol_led_keyer_top.sv
// ---------------------------------------------------------------------------
// morse_symbol_led_keyer_top
// Morse keyer: sends a stored symbol string as an on/off light level.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one word per item:
//   mode 0 is a time-unit tick, mode 1 writes write_char into the message
//   store at write_address. Every item returns exactly one output word
//   (out_valid/out_ready/out_data) with the light level after the item and
//   the message-changed flag, which is set on the tick that opens a new
//   message period. Software reloads the store when it sees the flag.
//   An accepted item waits in the execute stage until the output register is
//   free, executes, and its word is registered into the output register.
//   A new item is taken only after the previous one has executed: the store
//   read for a tick issues at acceptance and the read-modify-write of the
//   position completes at execution, before the next read address is known.
//   A stalled receiver holds the output register; one more item is still
//   accepted and parks in the execute stage until the register drains.
//   Reset clears counters, position and light, loads period_ticks 1800 and
//   blank_ticks 5. The store is not cleared; load it before sending ticks.
//   Configuration: APB, period_ticks at 0x0, blank_ticks at 0x4.
// ---------------------------------------------------------------------------
module morse_symbol_led_keyer_top #(
  parameter int MESSAGE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  mslk_pkg::in_word_t  in_data,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output mslk_pkg::out_word_t out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mslk_pkg::*;

  localparam int POS_W = $clog2(MESSAGE_DEPTH);

  // Configuration registers
  logic [15:0] period_ticks_r;
  logic [7:0]  blank_ticks_r;
  logic        cfg_wr;

  // Keyer state
  logic [POS_W-1:0] pos_r;
  cnt_t             ctr_r;

  // Message store and the shadow copy of entry 0 used by restart
  logic [7:0]       msg_mem_r [MESSAGE_DEPTH];
  logic [7:0]       rd_data_r;
  logic [7:0]       zero_char_r;
  logic [POS_W-1:0] rd_addr;

  // Execute stage and output register
  logic      busy_r;
  in_word_t  item_r;
  logic      out_valid_r;
  out_word_t out_data_r;

  logic             in_fire;
  logic             exec_fire;
  logic             wr_en;
  logic             addr_ok;
  logic [POS_W-1:0] wr_idx;
  logic [POS_W-1:0] step_pos;
  cnt_t             step_cnt;
  logic             step_chg;

  // --- configuration port -------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_PERIOD: prdata = {16'd0, period_ticks_r};
      REG_BLANK:  prdata = {24'd0, blank_ticks_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ticks_r <= PERIOD_RESET;
      blank_ticks_r  <= BLANK_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PERIOD: period_ticks_r <= pwdata[15:0];
        REG_BLANK:  blank_ticks_r  <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  // --- handshake ----------------------------------------------------------
  // Take a new word whenever the execute stage is empty; the execute stage
  // waits for the output register to drain.
  assign in_ready  = !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = busy_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (exec_fire) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  // --- message store ------------------------------------------------------
  // A period event sends the position back to 0 before the read, so read
  // there. State does not move between this read and its execution.
  assign rd_addr = (ctr_r.period_cnt == period_ticks_r) ? '0 : pos_r;

  assign addr_ok = (32'(item_r.write_address) < 32'(MESSAGE_DEPTH));
  assign wr_idx  = POS_W'(item_r.write_address);
  assign wr_en   = exec_fire && (item_r.mode == MODE_WRITE) && addr_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      msg_mem_r[wr_idx] <= item_r.write_char;
    end
    if (in_fire && in_data.mode == MODE_TICK) begin
      rd_data_r <= msg_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && item_r.write_address == 8'd0) begin
      zero_char_r <= item_r.write_char;
    end
  end

  // --- tick execution -----------------------------------------------------
  mslk_step #(
    .MESSAGE_DEPTH(MESSAGE_DEPTH)
  ) u_step (
    .pos          (pos_r),
    .cnt          (ctr_r),
    .period_ticks (period_ticks_r),
    .blank_ticks  (blank_ticks_r),
    .sym          (rd_data_r),
    .zero_sym     (zero_char_r),
    .pos_nxt      (step_pos),
    .cnt_nxt      (step_cnt),
    .changed      (step_chg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ctr_r <= '0;
    end else if (exec_fire && item_r.mode == MODE_TICK) begin
      pos_r <= step_pos;
      ctr_r <= step_cnt;
    end
  end

  // --- output register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      if (item_r.mode == MODE_TICK) begin
        out_data_r.light_on        <= step_cnt.light;
        out_data_r.message_changed <= step_chg;
      end else begin
        // write word: report the held light level
        out_data_r.light_on        <= ctr_r.light;
        out_data_r.message_changed <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/mslk_checker.sv
// ---------------------------------------------------------------------------
// mslk_checker
// Port-level checks of the Morse keyer, bound to the top level.
// ---------------------------------------------------------------------------
`include "morse_symbol_led_keyer_top_assert.svh"

module mslk_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mslk_pkg::out_word_t out_data
);
  import mslk_pkg::*;

  // one word in execution at a time
  `MSLK_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted twice in a row")

  // with an empty output register the word shows after the execute stage
  `MSLK_ASSERT_NOW(a_latency, in_valid && in_ready && !out_valid, ##2 out_valid, "late result")

  // a busy stage with a free output register drains in the next cycle
  `MSLK_ASSERT_NEXT(a_drain, !in_ready && !out_valid, in_ready, "execute stage stuck")

  // stalled result holds
  `MSLK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")

endmodule

bind morse_symbol_led_keyer_top mslk_checker u_mslk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/morse_symbol_led_keyer_top_test.sv
// ---------------------------------------------------------------------------
// Morse keyer regression
// Drives tick and store-write words into the keyer, predicts the light level
// and message-changed flag of every word with an in-bench keyer model, and
// checks each output word in order. Covers every symbol, blanking, period
// change events, position and unit counter wraps, and randomized traffic
// with random input gaps and random output back-pressure.
// ---------------------------------------------------------------------------
module morse_symbol_led_keyer_top_test;
  import mslk_pkg::*;

  // Longest stretch with no word moving on either channel before giving up
  localparam int WATCHDOG_LIMIT = 1000;
  // Settle time after the last output word
  localparam int TAIL_CYCLES    = 16;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  always #4 clk = ~clk;

  morse_symbol_led_keyer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // -------------------------------------------------------------------------
  // Keyer model state: message store with written marks, cursor, counters,
  // light level and the two configuration registers.
  // -------------------------------------------------------------------------
  logic [7:0]  msg_mem [0:255];
  bit          msg_written [0:255];
  logic [7:0]  cur_pos    = '0;
  logic [2:0]  unit_cnt   = '0;
  logic [15:0] period_cnt = '0;
  logic [7:0]  blank_cnt  = '0;
  logic        light_lvl  = 1'b0;
  logic [15:0] period_cfg = PERIOD_RESET;
  logic [7:0]  blank_cfg  = BLANK_RESET;

  // Light words still owed by the keyer, oldest first
  out_word_t   light_expect_q[$];

  int          fail_count = 0;
  bit          steady     = 1'b0;  // set: no idle cycles on either side
  int          stall_left = 0;
  int          quiet_cycles = 0;

  // Advance the keyer model by one input word and return the output word.
  function automatic out_word_t keyer_predict(input in_word_t w);
    out_word_t  r;
    logic [7:0] sym;
    logic [2:0] len;
    r.message_changed = 1'b0;
    if (w.mode == MODE_WRITE) begin
      msg_mem[w.write_address] = w.write_char;
      msg_written[w.write_address] = 1'b1;
    end else begin
      if (period_cnt == period_cfg) begin
        r.message_changed = 1'b1;
        blank_cnt  = blank_cfg;
        period_cnt = '0;
        unit_cnt   = '0;
        cur_pos    = '0;
      end
      if (blank_cnt != 0) begin
        light_lvl = 1'b0;
        blank_cnt = blank_cnt - 8'd1;
      end else begin
        period_cnt = period_cnt + 16'd1;
        sym = msg_mem[cur_pos];
        if (sym == SYM_RESTART) begin
          cur_pos = '0;
          sym = msg_mem[0];
        end
        case (sym)
          SYM_DOT, SYM_DASH: begin
            len = (sym == SYM_DOT) ? LEN_DOT : LEN_DASH;
            if (unit_cnt != len) begin
              light_lvl = 1'b1;
              unit_cnt  = unit_cnt + 3'd1;
            end else begin
              light_lvl = 1'b0;
              unit_cnt  = '0;
              cur_pos   = cur_pos + 8'd1;
            end
          end
          SYM_LETTER_GAP, SYM_WORD_GAP: begin
            len = (sym == SYM_LETTER_GAP) ? LEN_LETTER_GAP : LEN_WORD_GAP;
            light_lvl = 1'b0;
            unit_cnt  = unit_cnt + 3'd1;
            if (unit_cnt == len) begin
              unit_cnt = '0;
              cur_pos  = cur_pos + 8'd1;
            end
          end
          default: cur_pos = '0;
        endcase
      end
    end
    r.light_on = light_lvl;
    return r;
  endfunction

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  // Mostly legal symbols, now and then a restart or an arbitrary byte.
  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5)       return SYM_DOT;
    else if (r < 10) return SYM_DASH;
    else if (r < 13) return SYM_LETTER_GAP;
    else if (r < 16) return SYM_WORD_GAP;
    else if (r < 17) return SYM_RESTART;
    else             return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_word_t make_write(input logic [7:0] addr, input logic [7:0] ch);
    in_word_t w;
    w.mode          = MODE_WRITE;
    w.write_address = addr;
    w.write_char    = ch;
    return w;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // -------------------------------------------------------------------------
  // Input side. Hold valid and the word until accepted; keep valid high when
  // the next word follows with no gap so it is never dropped and re-raised
  // in the same step.
  // -------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    light_expect_q.push_back(keyer_predict(w));
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send one tick, first loading any store entry it would read that was
  // never written: the one under the cursor and, behind a restart, entry 0.
  task automatic send_tick();
    logic [7:0] addr;
    bit         change;
    in_word_t   w;
    change = (period_cnt == period_cfg);
    addr   = change ? 8'd0 : cur_pos;
    if (change ? (blank_cfg == 0) : (blank_cnt == 0)) begin
      if (!msg_written[addr]) send_word(make_write(addr, pick_symbol()));
      if (msg_mem[addr] == SYM_RESTART && !msg_written[0])
        send_word(make_write(8'd0, pick_symbol()));
    end
    w.mode          = MODE_TICK;
    w.write_address = 8'($urandom_range(0, 255));
    w.write_char    = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // Drop valid and wait until every owed output word has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (light_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram both registers with the keyer idle.
  task automatic set_config(input logic [15:0] period, input logic [7:0] blank);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_PERIOD, {16'd0, period});
    write_reg(REG_BLANK, {24'd0, blank});
    period_cfg = period;
    blank_cfg  = blank;
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Walk each symbol once at reset settings, then a restart and a bad byte.
  task automatic test_symbols();
    send_word(make_write(8'd0, SYM_DOT));
    send_word(make_write(8'd1, SYM_DASH));
    send_word(make_write(8'd2, SYM_LETTER_GAP));
    send_word(make_write(8'd3, SYM_WORD_GAP));
    send_word(make_write(8'd4, SYM_RESTART));
    send_word(make_write(8'd255, 8'h00));
    // dot 2, dash 4, letter gap 2, word gap 6, then restart into the dot
    repeat (15) send_tick();
    // unknown byte under the cursor: back to 0, light held
    send_word(make_write(8'd0, 8'hFF));
    repeat (2) send_tick();
  endtask

  // Blanking and change events over a spread of settings, extremes included.
  task automatic test_config_sweep();
    logic [15:0] periods [6] = '{16'd1, 16'd0, 16'd7, 16'd65535, 16'd0, 16'd3};
    logic [7:0]  blanks  [6] = '{8'd0, 8'd2, 8'd255, 8'd1, 8'd0, 8'd1};
    int          counts  [6] = '{40, 40, 300, 30, 30, 40};
    for (int s = 0; s < 6; s++) begin
      // open a new period first so each setting counts from zero
      set_config(period_cnt, blanks[s]);
      send_tick();
      set_config(periods[s], blanks[s]);
      repeat (counts[s]) send_tick();
    end
  endtask

  // Fill the whole store with dots and run the cursor past the last entry.
  task automatic test_position_wrap();
    set_config(16'd65535, 8'd0);
    for (int a = 0; a < 256; a++) send_word(make_write(8'(a), SYM_DOT));
    repeat (520) send_tick();
  endtask

  // Swap the symbol under the cursor mid-send so the unit count wraps:
  // a word gap reaches five units, then a dash counts on through seven.
  task automatic test_unit_wrap();
    set_config(period_cnt, 8'd0);
    send_word(make_write(8'd0, SYM_WORD_GAP));
    repeat (5) send_tick();
    send_word(make_write(8'd0, SYM_DASH));
    repeat (8) send_tick();
  endtask

  // Lower the period below the running count: no change event may come
  // before the period counter wraps, which is not reached here.
  task automatic test_period_lowered();
    set_config(16'd65535, 8'd0);
    while (period_cnt <= 16'd5) send_tick();
    set_config(16'd5, 8'd0);
    repeat (40) send_tick();
  endtask

  // Random traffic: mostly ticks over a mostly legal message, rewrites under
  // the cursor and scattered stores, with idle and no-idle stretches.
  task automatic test_random();
    int r;
    set_config(16'd97, 8'd4);
    for (int i = 0; i < 200; i++) begin
      if (i % 100 == 0) steady = (i % 200 != 0);
      // hold off once until the keyer has caught up completely
      if (i == 150) drain();
      r = $urandom_range(0, 9);
      if (r < 6)      send_tick();
      else if (r < 8) send_word(make_write(cur_pos, pick_symbol()));
      else            send_word(make_write(8'($urandom_range(0, 255)), pick_symbol()));
    end
    steady = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Output side: check every accepted word against the oldest prediction,
  // then draw the stall before the next one.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (light_expect_q.size() == 0) begin
          note_failure($sformatf("unexpected word light=%0b changed=%0b",
                                 out_data.light_on, out_data.message_changed));
        end else begin
          want = light_expect_q.pop_front();
          if (out_data.light_on !== want.light_on ||
              out_data.message_changed !== want.message_changed)
            note_failure($sformatf("light exp %0b got %0b, changed exp %0b got %0b",
                                   want.light_on, out_data.light_on,
                                   want.message_changed, out_data.message_changed));
        end
        stall_left = draw_gap();
        if (stall_left != 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (stall_left <= 1) out_ready <= 1'b1;
        stall_left = stall_left - 1;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_symbols();
    test_config_sweep();
    test_position_wrap();
    test_unit_wrap();
    test_period_lowered();
    test_random();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (light_expect_q.size() != 0)
      note_failure($sformatf("%0d words never arrived", light_expect_q.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
